### rtl/jacobi_3d_seven_point_stencil_macros.svh
// Assertion macros shared by the stencil checker.
`ifndef JACOBI_3D_SEVEN_POINT_STENCIL_MACROS_SVH
`define JACOBI_3D_SEVEN_POINT_STENCIL_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while rst is high.
`define JSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst is high.
`define JSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/jss_pkg.sv
// Shared constants for the 3D seven-point Jacobi stencil block.
package jss_pkg;

   localparam int MAX_GRID_DEF = 64;

   localparam int GRID_WIDTH   = 7;
   localparam int BORDER_WIDTH = 5;
   localparam int COEF_WIDTH   = 16;
   localparam int DATA_WIDTH   = 32;
   localparam int ADDR_WIDTH   = 4;

   localparam logic [1:0] REG_GRID   = 2'd0;
   localparam logic [1:0] REG_BORDER = 2'd1;
   localparam logic [1:0] REG_COEF   = 2'd2;

   localparam logic [GRID_WIDTH-1:0]   GRID_RESET   = 7'd64;
   localparam logic [BORDER_WIDTH-1:0] BORDER_RESET = 5'd2;
   localparam logic [COEF_WIDTH-1:0]   COEF_RESET   = 16'd9372;

endpackage

### rtl/jacobi_3d_seven_point_stencil.sv
// Top level of the 3D seven-point Jacobi stencil with its two-plane window memories.
// The block takes one voxel per clock cycle in raster order, x fastest, and returns one
// result for every interior voxel once the voxel one plane ahead has arrived; a result
// goes through the read, add, sum and product registers. The sustained rate of one item
// per cycle is set by the window: each item does one read-modify-write of its own entry
// and three reads of the plane behind, spread over two copies of the window memory with
// two read ports each. An eight-entry result queue lets the input keep flowing while the
// output stalls; the input stalls only when eight results are outstanding. No clearing
// pass follows reset. Writing grid_size restarts the sweep at voxel (0,0,0).
module jacobi_3d_seven_point_stencil #(
   parameter int MAX_GRID = jss_pkg::MAX_GRID_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [jss_pkg::DATA_WIDTH-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [jss_pkg::DATA_WIDTH-1:0] rsp_new_value,
   output logic                                rsp_last_result,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [jss_pkg::ADDR_WIDTH-1:0]      paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import jss_pkg::*;

   localparam int PW    = $clog2(MAX_GRID);
   localparam int GW    = $clog2(MAX_GRID + 1);
   localparam int CW0   = (GW > GRID_WIDTH) ? GW : GRID_WIDTH;
   localparam int CW    = ((CW0 > BORDER_WIDTH) ? CW0 : BORDER_WIDTH) + 2;
   localparam int PLANE = MAX_GRID * MAX_GRID;
   localparam int DEPTH = 2 * PLANE;
   localparam int AW    = $clog2(DEPTH);
   localparam int TW    = AW + CW;
   localparam int QD    = 8;
   localparam int QW    = $clog2(QD);

   typedef struct packed {
      logic                         last;
      logic signed [DATA_WIDTH-1:0] value;
   } rsp_entry_type;

   function automatic logic [AW-1:0] win_addr(input logic pl, input logic [CW-1:0] xa,
                                              input logic [CW-1:0] ya);
      logic [TW-1:0] t;
      t = TW'(ya) * TW'(MAX_GRID) + TW'(xa) + (pl ? TW'(PLANE) : TW'(0));
      return t[AW-1:0];
   endfunction

   // Configuration registers.
   logic [GRID_WIDTH-1:0]   grid_ff;
   logic [BORDER_WIDTH-1:0] border_ff;
   logic [COEF_WIDTH-1:0]   coef_ff;
   logic                    cfg_wr;

   // Sweep position.
   logic [PW-1:0] pos_x_ff, pos_y_ff, pos_z_ff;

   logic [CW-1:0] g, b, hi, edge_pos, xe, ye, ze, cz;
   logic          interior, last_in, accept, x_wrap, y_wrap, z_wrap;
   logic [AW-1:0] here_addr, row_addr, up_addr, down_addr;

   // Window memories, both holding the same two planes.
   logic [DATA_WIDTH-1:0] win_a_mem [DEPTH];
   logic [DATA_WIDTH-1:0] win_b_mem [DEPTH];

   logic signed [DATA_WIDTH-1:0] front_ff, back_ff, row_ff, up_ff, down_ff;
   logic signed [DATA_WIDTH-1:0] centre_ff, left_ff;

   logic        s1_v_ff, s1_res_ff, s1_last_ff;
   logic        s2_v_ff, s2_last_ff;
   logic        s3_v_ff, s3_last_ff;
   logic        s4_v_ff, s4_last_ff;
   logic signed [DATA_WIDTH:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [34:0]         sum_in, sum_ff;
   logic signed [51:0]         prod_in, prod_ff, rnd;
   logic signed [35:0]         quot;
   logic signed [DATA_WIDTH-1:0] sat_value;

   rsp_entry_type  queue_mem [QD];
   logic [QW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QW:0]    count_ff, pend_ff;
   logic           rsp_take;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_comb begin
      prdata = '0;
      unique case (paddr[3:2])
         REG_GRID:   prdata = 32'(grid_ff);
         REG_BORDER: prdata = 32'(border_ff);
         REG_COEF:   prdata = 32'(coef_ff);
         default:    prdata = '0;
      endcase
   end

   always_comb begin
      if (grid_ff == '0) begin
         g = CW'(1);
      end else if (CW'(grid_ff) > CW'(MAX_GRID)) begin
         g = CW'(MAX_GRID);
      end else begin
         g = CW'(grid_ff);
      end
      b        = (border_ff == '0) ? CW'(1) : CW'(border_ff);
      hi       = g - b;
      edge_pos = hi - CW'(1);
      xe       = CW'(pos_x_ff);
      ye       = CW'(pos_y_ff);
      ze       = CW'(pos_z_ff);
      cz       = ze - CW'(1);
      interior = (g > (b << 1)) && (ze != '0) && (xe >= b) && (xe < hi) &&
                 (ye >= b) && (ye < hi) && (cz >= b) && (cz < hi);
      last_in  = (xe == edge_pos) && (ye == edge_pos) && (cz == edge_pos);
      x_wrap   = (xe + CW'(1)) >= g;
      y_wrap   = (ye + CW'(1)) >= g;
      z_wrap   = (ze + CW'(1)) >= g;
      here_addr = win_addr(pos_z_ff[0], xe, ye);
      row_addr  = x_wrap ? win_addr(!pos_z_ff[0], CW'(0), ye + CW'(1))
                         : win_addr(!pos_z_ff[0], xe + CW'(1), ye);
      up_addr   = win_addr(!pos_z_ff[0], xe, ye - CW'(1));
      down_addr = win_addr(!pos_z_ff[0], xe, ye + CW'(1));
   end

   assign req_stall = (pend_ff == (QW+1)'(QD));
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff   <= GRID_RESET;
         border_ff <= BORDER_RESET;
         coef_ff   <= COEF_RESET;
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         pos_z_ff  <= '0;
      end else if (cfg_wr) begin
         unique case (paddr[3:2])
            REG_GRID: begin
               grid_ff  <= pwdata[GRID_WIDTH-1:0];
               pos_x_ff <= '0;
               pos_y_ff <= '0;
               pos_z_ff <= '0;
            end
            REG_BORDER: border_ff <= pwdata[BORDER_WIDTH-1:0];
            REG_COEF:   coef_ff <= pwdata[COEF_WIDTH-1:0];
            default: ;
         endcase
      end else if (accept) begin
         if (!x_wrap) begin
            pos_x_ff <= PW'(xe + CW'(1));
         end else begin
            pos_x_ff <= '0;
            if (!y_wrap) begin
               pos_y_ff <= PW'(ye + CW'(1));
            end else begin
               pos_y_ff <= '0;
               pos_z_ff <= z_wrap ? '0 : PW'(ze + CW'(1));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         back_ff              <= win_a_mem[here_addr];
         row_ff               <= win_a_mem[row_addr];
         win_a_mem[here_addr] <= req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         up_ff                <= win_b_mem[up_addr];
         down_ff              <= win_b_mem[down_addr];
         win_b_mem[here_addr] <= req_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_ff   <= req_sample;
         s1_res_ff  <= interior;
         s1_last_ff <= last_in;
      end
      if (s1_v_ff) begin
         centre_ff  <= row_ff;
         left_ff    <= centre_ff;
         p0_ff      <= 33'(front_ff) + 33'(back_ff);
         p1_ff      <= 33'(centre_ff) + 33'(left_ff);
         p2_ff      <= 33'(row_ff) + 33'(up_ff);
         p3_ff      <= 33'(down_ff);
         s2_last_ff <= s1_last_ff;
      end
      sum_ff     <= sum_in;
      s3_last_ff <= s2_last_ff;
      prod_ff    <= prod_in;
      s4_last_ff <= s3_last_ff;
   end

   assign sum_in  = 35'(p0_ff) + 35'(p1_ff) + 35'(p2_ff) + 35'(p3_ff);
   assign prod_in = 52'(sum_ff) * 52'($signed({1'b0, coef_ff}));
   assign rnd     = prod_ff + 52'sd32768;
   assign quot    = rnd[51:16];

   always_comb begin
      if (quot[35:31] == '0 || quot[35:31] == '1) begin
         sat_value = quot[31:0];
      end else if (quot[35]) begin
         sat_value = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= accept;
         s2_v_ff <= s1_v_ff && s1_res_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   assign rsp_valid       = (count_ff != '0);
   assign rsp_take        = rsp_valid && !rsp_stall;
   assign rsp_new_value   = queue_mem[rd_ptr_ff].value;
   assign rsp_last_result = queue_mem[rd_ptr_ff].last;

   always_ff @(posedge clock) begin
      if (s4_v_ff) begin
         queue_mem[wr_ptr_ff] <= '{last: s4_last_ff, value: sat_value};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         pend_ff   <= '0;
      end else begin
         if (s4_v_ff) begin
            wr_ptr_ff <= wr_ptr_ff + QW'(1);
         end
         if (rsp_take) begin
            rd_ptr_ff <= rd_ptr_ff + QW'(1);
         end
         count_ff <= count_ff + (QW+1)'(s4_v_ff) - (QW+1)'(rsp_take);
         pend_ff  <= pend_ff + (QW+1)'(accept && interior) - (QW+1)'(rsp_take);
      end
   end

endmodule

### rtl/jss_checker.sv
// Port-level checker for the stencil block and its bind to the top level.
`include "jacobi_3d_seven_point_stencil_macros.svh"

module jss_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [jss_pkg::DATA_WIDTH-1:0] rsp_new_value,
   input logic                                  rsp_last_result,
   input logic                                  psel,
   input logic                                  penable,
   input logic                                  pwrite,
   input logic [jss_pkg::ADDR_WIDTH-1:0]        paddr,
   input logic [31:0]                           pwdata,
   input logic [31:0]                           prdata
);
   import jss_pkg::*;

   // Reset empties the result queue.
   `JSS_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid, "result after reset")

   // A stalled item keeps its value and its last flag.
   `JSS_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_new_value) && $stable(rsp_last_result), "stalled item changed")

   // A coefficient write reads back on the next cycle.
   `JSS_ASSERT_NOW(a_coef_readback, clock, reset, $past(psel && penable && pwrite && paddr[3:2] == REG_COEF) && paddr[3:2] == REG_COEF, prdata[15:0] == $past(pwdata[15:0]) && prdata[31:16] == 16'h0, "coefficient readback wrong")

   // The boundary width reads its reset value right after reset.
   `JSS_ASSERT_NOW(a_border_reset, clock, reset, $past(reset) && paddr[3:2] == REG_BORDER, prdata == 32'(BORDER_RESET), "boundary width reset value wrong")

endmodule

bind jacobi_3d_seven_point_stencil jss_checker u_jss_checker (.*);
